FILE: src/twre_pkg.sv
// ----------------------------------------------------------------------------
// twre_pkg
// Types, register indexes, status codes and saturation and sign-extension helpers for the
// trimmed weighted ratio estimator.
// ----------------------------------------------------------------------------
package twre_pkg;

  localparam int REG_IDX_W = 3;
  localparam int WR_DATA_W = 32;
  localparam int DIV_W     = 64;

  localparam logic [REG_IDX_W-1:0] REG_TRIM  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CORR  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_START = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TOL   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_TRIM     = 2'd2;

  typedef struct packed {
    logic signed [31:0] exposure_effect;
    logic signed [31:0] outcome_effect;
    logic        [30:0] exposure_var;
    logic        [30:0] outcome_var;
    logic        [30:0] elem_weight;
    logic        [30:0] exposure_se;
    logic        [30:0] outcome_se;
    logic               last_element;
  } item_t;

  typedef struct packed {
    logic signed [31:0] exposure_effect;
    logic signed [31:0] outcome_effect;
    logic        [30:0] exposure_var;
    logic        [30:0] outcome_var;
    logic        [30:0] elem_weight;
    logic        [30:0] exposure_se;
    logic        [30:0] outcome_se;
  } elem_t;

  typedef struct packed {
    logic        [5:0]  element_index;
    logic signed [31:0] residual;
    logic signed [31:0] estimate;
    logic        [9:0]  iterations_used;
    logic        [1:0]  status;
    logic               last_result;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
    return 64'(v);
  endfunction

endpackage

FILE: src/trimmed_weighted_ratio_estimator.sv
// ----------------------------------------------------------------------------
// trimmed_weighted_ratio_estimator
// Loads elements into a store, then estimates a trimmed weighted ratio by
// iterated scoring, outlier selection and re-estimation; emits residuals.
// ----------------------------------------------------------------------------
// Load: one word per cycle until last_element; input then stalls for the run.
// Run: a ratio pass and a score pass over the elements (two 64-step
//   divisions per element in each), plus trim_count selection sweeps and
//   a final division per iteration.
// Emit: one result word per element; a stalled output holds the pass.
// Reset: control and configuration registers take their defaults at once; no
//   clearing pass is needed.
module trimmed_weighted_ratio_estimator #(
  parameter int MAX_ELEMENTS = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  twre_pkg::item_t                       item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output twre_pkg::result_t                     result,
  input  logic                                  wr_en,
  input  logic [twre_pkg::REG_IDX_W-1:0]        wr_index,
  input  logic [twre_pkg::WR_DATA_W-1:0]        wr_data
);
  import twre_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int SUM_W  = 33 + $clog2(MAX_ELEMENTS);
  localparam int DCNT_W = $clog2(DIV_W);

  typedef enum logic [7:0] {
    S_LOAD    = 8'b0000_0001,
    S_SETUP   = 8'b0000_0010,
    S_CHECK   = 8'b0000_0100,
    S_FETCH   = 8'b0000_1000,
    S_CALC    = 8'b0001_0000,
    S_RDIV    = 8'b0010_0000,
    S_SEL     = 8'b0100_0000,
    S_SEL_END = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    P_RATIO,
    P_SCORE,
    P_EMIT
  } pass_t;

  // configuration
  logic        [6:0]  trim_count;
  logic        [9:0]  iteration_limit;
  logic signed [17:0] correlation;
  logic signed [31:0] start_estimate;
  logic        [15:0] stop_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_count      <= '0;
      iteration_limit <= 10'd100;
      correlation     <= '0;
      start_estimate  <= '0;
      stop_tolerance  <= 16'd1;
    end else if (wr_en) begin
      case (wr_index)
        REG_TRIM:  trim_count      <= wr_data[6:0];
        REG_LIMIT: iteration_limit <= wr_data[9:0];
        REG_CORR:  correlation     <= wr_data[17:0];
        REG_START: start_estimate  <= wr_data;
        REG_TOL:   stop_tolerance  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  state_t state;
  pass_t  pass;
  logic [3:0]          st;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    count;
  logic [MAX_ELEMENTS-1:0] mark;
  logic [9:0]          iter;
  logic signed [31:0]  theta;
  logic signed [31:0]  prev_est;
  logic [1:0]          status;
  logic [32:0]         dlx;
  logic signed [SUM_W-1:0] sa;
  logic signed [SUM_W-1:0] sb;
  logic signed [31:0]  ta;
  logic signed [31:0]  tb;
  logic signed [33:0]  tc;
  logic [6:0]          k;
  logic [CNT_W-1:0]    sel_cnt;
  logic                sel_v;
  logic [IDX_W-1:0]    sel_j;
  logic                have;
  logic signed [31:0]  best;
  logic [IDX_W-1:0]    bi;
  logic                res_valid;
  logic                res_load;
  result_t             res;

  logic accept;
  assign item_stall   = (state != S_LOAD);
  assign accept       = item_valid && !item_stall;
  assign result_valid = res_valid;
  assign result       = res;

  // element store
  elem_t elem_mem [MAX_ELEMENTS];
  elem_t ed;
  elem_t elem_wdata;
  logic  mem_we;
  logic  mem_re;

  always_comb begin
    elem_wdata.exposure_effect = item.exposure_effect;
    elem_wdata.outcome_effect  = item.outcome_effect;
    elem_wdata.exposure_var    = item.exposure_var;
    elem_wdata.outcome_var     = item.outcome_var;
    elem_wdata.elem_weight     = item.elem_weight;
    elem_wdata.exposure_se     = item.exposure_se;
    elem_wdata.outcome_se      = item.outcome_se;
  end

  assign mem_we = accept && (count != CNT_W'(MAX_ELEMENTS));
  assign mem_re = (state == S_FETCH);

  always_ff @(posedge clk) begin
    if (mem_we) elem_mem[count[IDX_W-1:0]] <= elem_wdata;
    if (mem_re) ed <= elem_mem[idx[IDX_W-1:0]];
  end

  // score store
  logic signed [31:0] sc_mem [MAX_ELEMENTS];
  logic signed [31:0] sc_q;
  logic signed [31:0] qm;
  logic               sc_we;

  assign sc_we = (state == S_CALC) && (pass == P_SCORE) && (st == 4'd14);

  always_ff @(posedge clk) begin
    if (sc_we) sc_mem[idx[IDX_W-1:0]] <= qm;
    if (state == S_SEL) sc_q <= sc_mem[sel_cnt[IDX_W-1:0]];
  end

  // element fields
  logic signed [31:0] bx, by, vx, vy, w, sxe, sye, rho32;
  assign bx    = ed.exposure_effect;
  assign by    = ed.outcome_effect;
  assign vx    = $signed({1'b0, ed.exposure_var});
  assign vy    = $signed({1'b0, ed.outcome_var});
  assign w     = $signed({1'b0, ed.elem_weight});
  assign sxe   = $signed({1'b0, ed.exposure_se});
  assign sye   = $signed({1'b0, ed.outcome_se});
  assign rho32 = 32'(correlation);

  // shared multiplier, product registered
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_q;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    if (state == S_CALC) begin
      case (pass)
        P_RATIO: begin
          case (st)
            4'd0: begin mul_en = 1'b1; mul_a = bx;    mul_b = bx;  end
            4'd3: begin mul_en = 1'b1; mul_a = w;     mul_b = tb;  end
            4'd4: begin mul_en = 1'b1; mul_a = sxe;   mul_b = sye; end
            4'd5: begin mul_en = 1'b1; mul_a = rho32; mul_b = qm;  end
            4'd6: begin mul_en = 1'b1; mul_a = bx;    mul_b = by;  end
            4'd9: begin mul_en = 1'b1; mul_a = w;     mul_b = tb;  end
            default: ;
          endcase
        end
        P_SCORE: begin
          case (st)
            4'd0:  begin mul_en = 1'b1; mul_a = theta; mul_b = bx;    end
            4'd2:  begin mul_en = 1'b1; mul_a = ta;    mul_b = ta;    end
            4'd5:  begin mul_en = 1'b1; mul_a = theta; mul_b = theta; end
            4'd6:  begin mul_en = 1'b1; mul_a = qm;    mul_b = vx;    end
            4'd9:  begin mul_en = 1'b1; mul_a = theta; mul_b = rho32; end
            4'd10: begin mul_en = 1'b1; mul_a = sxe;   mul_b = sye;   end
            4'd11: begin mul_en = 1'b1; mul_a = tb;    mul_b = qm;    end
            4'd13: begin mul_en = 1'b1; mul_a = w;     mul_b = sat32(64'(tc)); end
            default: ;
          endcase
        end
        P_EMIT: begin
          if (st == 4'd0) begin
            mul_en = 1'b1;
            mul_a  = theta;
            mul_b  = bx;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_q <= mul_a * mul_b;
  end

  assign qm = sat32(prod_q >>> FRAC_BITS);

  // shared restoring divider, one quotient bit per cycle
  logic                    div_step;
  logic                    div_go;
  logic signed [DIV_W-1:0] div_num, div_den;
  logic [DIV_W-1:0]        nmag, dmag_n, dmag, quo, rem, rem_nx;
  logic [DIV_W:0]          rem_s;
  logic                    ge;
  logic                    div_busy, div_fin, dneg;
  logic [DCNT_W-1:0]       dcnt;
  logic signed [31:0]      div_res;

  always_comb begin
    div_step = 1'b0;
    div_num  = sx64(ta) <<< FRAC_BITS;
    div_den  = sx64(vy);
    if (state == S_RDIV) begin
      div_step = 1'b1;
      div_num  = 64'(sb) <<< FRAC_BITS;
      div_den  = 64'(sa);
    end else if (state == S_CALC) begin
      if (pass == P_RATIO && (st == 4'd2 || st == 4'd8)) div_step = 1'b1;
      if (pass == P_SCORE && (st == 4'd4 || st == 4'd8)) begin
        div_step = 1'b1;
        div_num  = sx64(tb) <<< FRAC_BITS;
      end
    end
  end

  assign div_go = div_step && !div_busy && !div_fin;
  assign nmag   = div_num[DIV_W-1] ? DIV_W'(-div_num) : div_num;
  assign dmag_n = div_den[DIV_W-1] ? DIV_W'(-div_den) : div_den;
  assign rem_s  = {rem, quo[DIV_W-1]};
  assign ge     = rem_s >= {1'b0, dmag};
  assign rem_nx = ge ? DIV_W'(rem_s - {1'b0, dmag}) : rem_s[DIV_W-1:0];

  always_comb begin
    if (dneg) begin
      div_res = (quo > 64'd2147483648) ? 32'sh80000000 : 32'(64'd0 - quo);
    end else begin
      div_res = (quo > 64'd2147483647) ? 32'sh7fffffff : quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_fin  <= 1'b0;
    end else begin
      div_fin <= 1'b0;
      if (div_go) begin
        if (div_den == '0) div_fin <= 1'b1;
        else div_busy <= 1'b1;
      end else if (div_busy && dcnt == DCNT_W'(DIV_W - 1)) begin
        div_busy <= 1'b0;
        div_fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_go) begin
      quo  <= (div_den == '0) ? '0 : nmag;
      rem  <= '0;
      dmag <= dmag_n;
      dneg <= div_num[DIV_W-1] ^ div_den[DIV_W-1];
      dcnt <= '0;
    end else if (div_busy) begin
      rem  <= rem_nx;
      quo  <= {quo[DIV_W-2:0], ge};
      dcnt <= dcnt + 1'b1;
    end
  end

  // sequencer
  logic signed [63:0] d64;
  assign d64 = sx64(prev_est) - sx64(div_res);

  // a result word is loaded this cycle
  assign res_load = (state == S_CALC) && (pass == P_EMIT) && (st != 4'd0) &&
                    (!res_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      pass      <= P_RATIO;
      st        <= '0;
      idx       <= '0;
      count     <= '0;
      mark      <= '0;
      iter      <= '0;
      theta     <= '0;
      prev_est  <= '0;
      status    <= ST_OK;
      k         <= '0;
      sel_cnt   <= '0;
      sel_v     <= 1'b0;
      have      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      sel_v <= (state == S_SEL) && (sel_cnt != count);
      sel_j <= sel_cnt[IDX_W-1:0];
      if (res_valid && !result_stall && !res_load) res_valid <= 1'b0;

      case (state)
        S_LOAD: begin
          if (accept) begin
            if (mem_we) count <= count + 1'b1;
            if (item.last_element) state <= S_SETUP;
          end
        end

        S_SETUP: begin
          mark     <= '0;
          iter     <= '0;
          prev_est <= start_estimate;
          dlx      <= 33'(1) << FRAC_BITS;
          idx      <= '0;
          if (trim_count == '0) begin
            theta  <= start_estimate;
            status <= ST_OK;
            sa     <= '0;
            sb     <= '0;
            pass   <= P_RATIO;
            state  <= S_FETCH;
          end else if (8'(trim_count) >= 8'(count)) begin
            status <= ST_TRIM;
            theta  <= '0;
            pass   <= P_EMIT;
            state  <= S_FETCH;
          end else begin
            theta  <= start_estimate;
            status <= ST_OK;
            state  <= S_CHECK;
          end
        end

        S_CHECK: begin
          idx <= '0;
          if (dlx > 33'(stop_tolerance) && iter < iteration_limit) begin
            prev_est <= theta;
            iter     <= iter + 1'b1;
            pass     <= P_SCORE;
          end else begin
            pass <= P_EMIT;
          end
          state <= S_FETCH;
        end

        S_FETCH: begin
          st <= '0;
          if (idx == count) begin
            case (pass)
              P_SCORE: begin
                mark    <= '0;
                k       <= '0;
                sel_cnt <= '0;
                have    <= 1'b0;
                state   <= S_SEL;
              end
              P_RATIO: begin
                if (sa == '0) begin
                  status <= ST_ZERO_DEN;
                  theta  <= '0;
                  mark   <= '0;
                  idx    <= '0;
                  pass   <= P_EMIT;
                end else begin
                  state <= S_RDIV;
                end
              end
              default: begin
                count <= '0;
                state <= S_LOAD;
              end
            endcase
          end else if (pass == P_RATIO && mark[idx[IDX_W-1:0]]) begin
            // skip outliers
            idx <= idx + 1'b1;
          end else begin
            state <= S_CALC;
          end
        end

        S_CALC: begin
          case (pass)
            P_RATIO: begin
              case (st)
                4'd1: begin ta <= sat32(sx64(qm) - sx64(vx)); st <= st + 1'b1; end
                4'd2, 4'd8: begin
                  if (div_fin) begin
                    tb <= div_res;
                    st <= st + 1'b1;
                  end
                end
                4'd4: begin sa <= sa + SUM_W'(qm); st <= st + 1'b1; end
                4'd6: begin ta <= qm; st <= st + 1'b1; end
                4'd7: begin ta <= sat32(sx64(qm) - sx64(ta)); st <= st + 1'b1; end
                4'd10: begin
                  sb    <= sb + SUM_W'(qm);
                  idx   <= idx + 1'b1;
                  state <= S_FETCH;
                end
                default: st <= st + 1'b1;
              endcase
            end
            P_SCORE: begin
              case (st)
                4'd1: begin ta <= sat32(sx64(by) - sx64(qm)); st <= st + 1'b1; end
                4'd3, 4'd7, 4'd10: begin tb <= qm; st <= st + 1'b1; end
                4'd4: begin
                  if (div_fin) begin
                    tc <= 34'(div_res);
                    st <= st + 1'b1;
                  end
                end
                4'd8: begin
                  if (div_fin) begin
                    tc <= tc - 34'(div_res);
                    st <= st + 1'b1;
                  end
                end
                4'd12: begin
                  tc <= tc + 34'(sat32(sx64(qm) + sx64(qm)));
                  st <= st + 1'b1;
                end
                4'd14: begin
                  idx   <= idx + 1'b1;
                  state <= S_FETCH;
                end
                default: st <= st + 1'b1;
              endcase
            end
            default: begin
              if (st == 4'd0) begin
                st <= st + 1'b1;
              end else if (!res_valid || !result_stall) begin
                res_valid             <= 1'b1;
                res.element_index     <= 6'(idx);
                res.residual          <= mark[idx[IDX_W-1:0]] ?
                                         sat32(sx64(by) - sx64(qm)) : '0;
                res.estimate          <= theta;
                res.iterations_used   <= iter;
                res.status            <= status;
                res.last_result       <= (CNT_W'(idx + 1'b1) == count);
                idx                   <= idx + 1'b1;
                state                 <= S_FETCH;
              end
            end
          endcase
        end

        S_RDIV: begin
          if (div_fin) begin
            theta <= div_res;
            idx   <= '0;
            if (trim_count == '0) begin
              pass  <= P_EMIT;
              state <= S_FETCH;
            end else begin
              dlx   <= d64[63] ? 33'(-d64) : 33'(d64);
              state <= S_CHECK;
            end
          end
        end

        S_SEL: begin
          // take the highest score among unmarked; earlier index wins a tie
          if (sel_v && !mark[sel_j] && (!have || sc_q > best)) begin
            have <= 1'b1;
            best <= sc_q;
            bi   <= sel_j;
          end
          if (sel_cnt == count) state <= S_SEL_END;
          else sel_cnt <= sel_cnt + 1'b1;
        end

        S_SEL_END: begin
          mark[bi] <= 1'b1;
          have     <= 1'b0;
          sel_cnt  <= '0;
          if (7'(k + 7'd1) == trim_count) begin
            idx   <= '0;
            sa    <= '0;
            sb    <= '0;
            pass  <= P_RATIO;
            state <= S_FETCH;
          end else begin
            k     <= k + 1'b1;
            state <= S_SEL;
          end
        end

        default: state <= S_LOAD;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count beyond store depth");

  a_err_no_residual: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK) |-> (result.residual == '0))
    else $error("residual nonzero on failed run");

  a_sel_unmarked: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL_END) |-> !mark[bi])
    else $error("selected element already marked");

  a_div_origin: assert property (@(posedge clk) disable iff (rst)
    div_fin |-> ($past(div_busy) || $past(div_go)))
    else $error("divider finished without a start");

endmodule

FILE: test/twre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twre_checker
// Watches the item, result and register ports of the estimator, predicts
// every result word from the accepted items and compares them in order.
// ----------------------------------------------------------------------------
module twre_checker
  import twre_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  item_t                item,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  result_t              result,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [WR_DATA_W-1:0] wr_data,
  output int                   fails,
  output int                   pending
);

  localparam int NMAX = 64;
  localparam int FB   = 16;

  longint ex_eff[NMAX], out_eff[NMAX], ex_var[NMAX], out_var[NMAX];
  longint weight[NMAX], ex_se[NMAX], out_se[NMAX];
  bit     is_outlier[NMAX];
  int     stored;

  int     trim;
  int     iter_limit;
  longint rho;
  longint theta_start;
  longint tol;

  result_t expected_words[$];

  initial pending = 0;

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b;
    return sat(p >>> FB);
  endfunction

  function automatic longint qdiv(input longint n, input longint d);
    if (d == 0) return 0;
    return sat((n * (64'sd1 <<< FB)) / d);
  endfunction

  // Ratio over the kept elements; zero denominator returns 0.
  function automatic bit weighted_ratio(input int n, output longint theta);
    longint sa, sb, t;
    sa = 0;
    sb = 0;
    theta = 0;
    for (int i = 0; i < n; i++) begin
      if (is_outlier[i]) continue;
      t = sat(qmul(ex_eff[i], ex_eff[i]) - ex_var[i]);
      sa += qmul(weight[i], qdiv(t, out_var[i]));
      t = sat(qmul(ex_eff[i], out_eff[i]) - qmul(rho, qmul(ex_se[i], out_se[i])));
      sb += qmul(weight[i], qdiv(t, out_var[i]));
    end
    if (sa == 0) return 0;
    theta = qdiv(sb, sa);
    return 1;
  endfunction

  function automatic void mark_worst(input int n, input longint theta);
    longint score[NMAX];
    longint r, s1, s2, s3;
    int rank;
    for (int i = 0; i < n; i++) begin
      r  = sat(out_eff[i] - qmul(theta, ex_eff[i]));
      s1 = qdiv(qmul(r, r), out_var[i]);
      s2 = qdiv(qmul(qmul(theta, theta), ex_var[i]), out_var[i]);
      s3 = sat(2 * qmul(qmul(theta, rho), qmul(ex_se[i], out_se[i])));
      score[i] = qmul(weight[i], sat(s1 - s2 + s3));
    end
    for (int i = 0; i < n; i++) begin
      rank = 0;
      for (int j = 0; j < n; j++)
        if (score[j] > score[i] || (score[j] == score[i] && j < i)) rank++;
      is_outlier[i] = rank < trim;
    end
  endfunction

  function automatic void estimate_run();
    int      n, iters;
    logic [1:0] st;
    longint  theta, prev, delta;
    result_t w;
    n = stored;
    iters = 0;
    st = ST_OK;
    theta = theta_start;
    for (int i = 0; i < NMAX; i++) is_outlier[i] = 0;
    if (trim == 0) begin
      if (!weighted_ratio(n, theta)) st = ST_ZERO_DEN;
    end else if (trim >= n) begin
      st = ST_TRIM;
    end else begin
      delta = 64'sd1 <<< FB;
      while (delta > tol && iters < iter_limit) begin
        prev = theta;
        iters++;
        mark_worst(n, theta);
        if (!weighted_ratio(n, theta)) begin
          st = ST_ZERO_DEN;
          break;
        end
        delta = prev - theta;
        if (delta < 0) delta = -delta;
      end
    end
    if (st != ST_OK) begin
      theta = 0;
      for (int i = 0; i < NMAX; i++) is_outlier[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      w.element_index   = i[5:0];
      w.residual        = is_outlier[i] ?
                          32'(sat(out_eff[i] - qmul(theta, ex_eff[i]))) : 32'sd0;
      w.estimate        = theta[31:0];
      w.iterations_used = iters[9:0];
      w.status          = st;
      w.last_result     = (i + 1 == n);
      expected_words.push_back(w);
    end
    stored = 0;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    fails++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      stored = 0;
      trim = 0;
      iter_limit = 100;
      rho = 0;
      theta_start = 0;
      tol = 1;
      fails = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_TRIM:  trim = int'(wr_data[6:0]);
          REG_LIMIT: iter_limit = int'(wr_data[9:0]);
          REG_CORR:  rho = longint'($signed(wr_data[17:0]));
          REG_START: theta_start = longint'($signed(wr_data));
          REG_TOL:   tol = longint'(wr_data[15:0]);
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        if (stored < NMAX) begin
          ex_eff[stored]  = longint'(item.exposure_effect);
          out_eff[stored] = longint'(item.outcome_effect);
          ex_var[stored]  = longint'(item.exposure_var);
          out_var[stored] = longint'(item.outcome_var);
          weight[stored]  = longint'(item.elem_weight);
          ex_se[stored]   = longint'(item.exposure_se);
          out_se[stored]  = longint'(item.outcome_se);
          stored++;
        end
        if (item.last_element) estimate_run();
      end
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          fails++;
          $display("unexpected result word at %0t", $time);
        end else begin
          want = expected_words.pop_front();
          if (result.element_index !== want.element_index)
            report("element_index", result.element_index, want.element_index);
          if (result.residual !== want.residual)
            report("residual", result.residual, want.residual);
          if (result.estimate !== want.estimate)
            report("estimate", result.estimate, want.estimate);
          if (result.iterations_used !== want.iterations_used)
            report("iterations_used", result.iterations_used, want.iterations_used);
          if (result.status !== want.status)
            report("status", result.status, want.status);
          if (result.last_result !== want.last_result)
            report("last_result", result.last_result, want.last_result);
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the trimmed weighted ratio estimator: directed data sets for
// the corner cases, then random sets under random register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import twre_pkg::*;

  localparam int WATCHDOG = 5000000;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 item_valid = 0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 0;
  result_t              result;
  logic                 wr_en = 0;
  logic [REG_IDX_W-1:0] wr_index = REG_TRIM;
  logic [WR_DATA_W-1:0] wr_data = '0;
  int                   fails, pending;
  bit                   idling = 1;
  int                   quiet_cycles = 0;
  int                   items_sent = 0;

  always #10 clk = ~clk;

  trimmed_weighted_ratio_estimator dut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall,
    .result, .wr_en, .wr_index, .wr_data
  );

  twre_checker chk (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall,
    .result, .wr_en, .wr_index, .wr_data, .fails, .pending
  );

  always @(posedge clk) begin
    result_stall <= idling && !rst && ($urandom_range(99) < 15);
  end

  // Bail out when neither channel moves for too long.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || rst) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_word(input item_t w);
    while (idling && $urandom_range(99) < 15) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    item <= w;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  // Hold until every result has drained and the block has settled.
  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (pending != 0 || item_stall) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_regs(input int trim, input int lim, input int corr,
                          input int start, input int tol);
    logic [WR_DATA_W-1:0] vals[5];
    logic [REG_IDX_W-1:0] idx[5];
    vals = '{trim, lim, corr, start, tol};
    idx  = '{REG_TRIM, REG_LIMIT, REG_CORR, REG_START, REG_TOL};
    drain();
    for (int i = 0; i < 5; i++) begin
      wr_en <= 1;
      wr_index <= idx[i];
      wr_data <= vals[i];
      @(posedge clk);
    end
    wr_en <= 0;
  endtask

  function automatic item_t make_word(input bit wild);
    item_t w;
    logic [223:0] raw;
    if (wild) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(item_t)-1:0];
    end else begin
      w.exposure_effect = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      w.outcome_effect  = $signed($urandom_range(0, 16 << 16)) - (8 << 16);
      w.exposure_var    = 31'($urandom_range(0, 1 << 15));
      w.outcome_var     = ($urandom_range(19) == 0) ? 31'd0 :
                          31'($urandom_range(1, 2 << 16));
      w.elem_weight     = 31'($urandom_range(0, 2 << 16));
      w.exposure_se     = 31'($urandom_range(0, 1 << 16));
      w.outcome_se      = 31'($urandom_range(0, 1 << 16));
    end
    w.last_element = 0;
    return w;
  endfunction

  task automatic send_set(input int n, input int wild_pct);
    item_t w;
    for (int i = 0; i < n; i++) begin
      w = make_word($urandom_range(99) < wild_pct);
      w.last_element = (i == n - 1);
      send_word(w);
    end
  endtask

  initial begin
    item_t w;
    int n;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // default registers: plain ratio
    send_set(1, 0);
    w = '{32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 31'h7fffffff,
          31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 1'b0};
    send_word(w);
    w = '{32'sh80000000, 32'sh7fffffff, 31'h0, 31'h0, 31'h0, 31'h0, 31'h0, 1'b0};
    send_word(w);
    w = make_word(0);
    w.last_element = 1;
    send_word(w);

    // zero denominator
    set_regs(0, 100, 0, 0, 1);
    w = make_word(0);
    w.exposure_effect = 0;
    w.exposure_var = 0;
    send_word(w);
    w.last_element = 1;
    send_word(w);

    // trim count at or above element count
    set_regs(1, 5, 0, 0, 1);
    send_set(1, 0);
    set_regs(64, 5, 0, 0, 1);
    send_set(3, 0);

    // zero iteration limit keeps the start estimate
    set_regs(1, 0, 0, 32'h80000000, 0);
    send_set(3, 0);

    // correlation extremes, tolerance extremes, long limit that converges fast
    set_regs(1, 3, 65536, 32'h7fffffff, 0);
    send_set(4, 0);
    set_regs(2, 1023, -65536, 1 << 16, 65535);
    send_set(4, 0);

    // full store: the extra element is dropped, its flag still starts the run
    set_regs(0, 100, 0, 0, 1);
    send_set(65, 10);
    set_regs(2, 2, 12345, 0, 100);
    send_set(24, 0);

    // random sets; one run of sets with no idling at all
    for (int k = 0; items_sent < 160; k++) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      set_regs($urandom_range(3) == 0 ? 0 : $urandom_range(0, n),
               $urandom_range(0, 6),
               $urandom_range(0, 131072) - 65536,
               $signed($urandom_range(0, 4 << 16)) - (2 << 16),
               $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 64));
      idling = !(k >= 2 && k < 8);
      send_set(n, 25);
    end

    drain();
    if (fails == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
